FILE: hdl/qsv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers of the qubit state-vector gate engine.
package qsv_pkg;

  localparam int MAX_QUBITS = 10;
  localparam int AMP_W      = 18;
  localparam int FRAC_BITS  = 16;
  localparam int MAT_W      = 18;

  localparam int ADDR_W  = MAX_QUBITS;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int WORD_W  = 2 * AMP_W;
  localparam int NQ_W    = $clog2(MAX_QUBITS + 1);
  localparam int MODE_W  = 2;
  localparam int QIDX_W  = 4;
  localparam int RIDX_W  = 10;
  localparam int QCNT_W  = 4;
  localparam int PROD_W  = AMP_W + MAT_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int RS_W    = ACC_W - FRAC_BITS + 1;
  localparam int CMP_W   = ((QIDX_W > NQ_W) ? QIDX_W : NQ_W) + 1;
  localparam int LCMP_W  = ((RIDX_W > MAX_QUBITS) ? RIDX_W : MAX_QUBITS) + 1;

  localparam int MAC_STEP_W = 4;
  localparam int MAC_CNT_W  = MAC_STEP_W + 1;
  localparam int MAC_STEPS  = 1 << MAC_STEP_W;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_QUBIT_COUNT = '0;
  localparam logic [QCNT_W-1:0]  QCNT_RESET      = QCNT_W'(1);

  localparam longint AmpMaxL = (longint'(1) << (AMP_W - 1)) - 1;
  localparam longint OneL    = ((longint'(1) << FRAC_BITS) > AmpMaxL) ?
                               AmpMaxL : (longint'(1) << FRAC_BITS);

  typedef logic signed [AMP_W-1:0]  amp_t;
  typedef logic signed [MAT_W-1:0]  mat_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [RS_W-1:0]   rs_t;

  localparam amp_t AMP_MAX = AMP_W'(AmpMaxL);
  localparam amp_t AMP_MIN = AMP_W'(-AmpMaxL - 1);
  localparam amp_t AMP_ONE = AMP_W'(OneL);
  localparam rs_t  RS_MAX  = RS_W'(AmpMaxL);
  localparam rs_t  RS_MIN  = RS_W'(-AmpMaxL - 1);
  localparam logic [ACC_W:0] RND_BIAS = (ACC_W + 1)'(longint'(1) << (FRAC_BITS - 1));

  typedef struct packed {
    amp_t re;
    amp_t im;
  } cplx_t;

  typedef struct packed {
    mat_t re;
    mat_t im;
  } mcplx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_GROUND = 2'd0,
    MODE_GATE   = 2'd1,
    MODE_CNOT   = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_LD_B,
    ST_MAC,
    ST_WR_A,
    ST_WR_B,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic                  issue;
    logic [MAC_STEP_W-1:0] step;
  } mac_ctrl_t;

  // Takes a sum with twice the fraction bits down to FRAC_BITS, rounding half up,
  // then clamps it to the amplitude range.
  function automatic amp_t round_sat(input acc_t acc);
    logic [ACC_W:0] biased;
    rs_t            shr;
    biased = {acc[ACC_W-1], acc} + RND_BIAS;
    shr    = rs_t'(biased[ACC_W:FRAC_BITS]);
    if (shr > RS_MAX) begin
      return AMP_MAX;
    end else if (shr < RS_MIN) begin
      return AMP_MIN;
    end
    return shr[AMP_W-1:0];
  endfunction

endpackage

FILE: hdl/qsv_in_if.sv
`timescale 1ns / 1ps
// Input channel of the gate engine: one command transaction.
interface qsv_in_if;
  import qsv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [QIDX_W-1:0]        target_qubit;
  logic [QIDX_W-1:0]        control_qubit;
  logic signed [MAT_W-1:0]  u0_re;
  logic signed [MAT_W-1:0]  u0_im;
  logic signed [MAT_W-1:0]  u1_re;
  logic signed [MAT_W-1:0]  u1_im;
  logic signed [MAT_W-1:0]  u2_re;
  logic signed [MAT_W-1:0]  u2_im;
  logic signed [MAT_W-1:0]  u3_re;
  logic signed [MAT_W-1:0]  u3_im;
  logic [RIDX_W-1:0]        read_index;

  modport source (
    output valid, mode, target_qubit, control_qubit,
    output u0_re, u0_im, u1_re, u1_im, u2_re, u2_im, u3_re, u3_im, read_index,
    input  ready
  );

  modport sink (
    input  valid, mode, target_qubit, control_qubit,
    input  u0_re, u0_im, u1_re, u1_im, u2_re, u2_im, u3_re, u3_im, read_index,
    output ready
  );
endinterface

FILE: hdl/qsv_out_if.sv
`timescale 1ns / 1ps
// Output channel of the gate engine: one result transaction.
interface qsv_out_if;
  import qsv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [AMP_W-1:0] amp_re;
  logic signed [AMP_W-1:0] amp_im;
  logic                    status;

  modport source (
    output valid, amp_re, amp_im, status,
    input  ready
  );

  modport sink (
    input  valid, amp_re, amp_im, status,
    output ready
  );
endinterface

FILE: hdl/qubit_state_vector_gate_engine.sv
`timescale 1ns / 1ps
// Gate: 2^(n-1) pairs, each through the single shared multiplier.
// Controlled-NOT: pairs with the control bit set are swapped, the other pairs are skipped.
// One command at a time; a finished result waits in the output register.
// After rst_ni the 1024-entry store is swept in a clearing pass, not ready.
module qubit_state_vector_gate_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  qsv_in_if.sink                       in_i,
  qsv_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [qsv_pkg::PADDR_W-1:0]  paddr,
  input  logic [qsv_pkg::PDATA_W-1:0]  pwdata,
  output logic [qsv_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import qsv_pkg::*;

  state_e                state_q, state_d;
  logic                  item_q, item_d;
  logic [ADDR_W-1:0]     pair_q, pair_d;
  logic [MAC_CNT_W-1:0]  step_q, step_d;
  logic [QCNT_W-1:0]     qcount_q;
  logic                  out_valid_q, out_valid_d;

  mode_e                 mode_q;
  logic [QIDX_W-1:0]     tq_q;
  logic [QIDX_W-1:0]     cq_q;
  logic [RIDX_W-1:0]     ridx_q;
  mcplx_t [3:0]          u_q;
  logic                  err_q;
  cplx_t                 a_q;
  cplx_t                 b_q;
  amp_t                  out_re_q;
  amp_t                  out_im_q;
  logic                  out_status_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic [NQ_W-1:0]       n_eff;
  logic                  tq_bad, cq_bad, ridx_bad;
  logic                  err_in, noop_in;
  logic [ADDR_W-1:0]     tbit, cbit, low_mask, addr_i, addr_j, pair_last;
  logic                  last_pair, skip_pair, clear_end, mac_done;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  cplx_t                 ram_wdata, ram_rdata;
  mac_ctrl_t             mac_ctrl;
  cplx_t                 new_a, new_b;

  logic                  cfg_we;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_QUBIT_COUNT);
  assign prdata = (paddr[PADDR_W-1:2] == REG_QUBIT_COUNT) ? PDATA_W'(qcount_q) : '0;

  // Command decode on the input port
  always_comb begin
    n_eff    = (qcount_q > MAX_QUBITS) ? NQ_W'(MAX_QUBITS) : NQ_W'(qcount_q);
    tq_bad   = CMP_W'(in_i.target_qubit) >= CMP_W'(n_eff);
    cq_bad   = CMP_W'(in_i.control_qubit) >= CMP_W'(n_eff);
    ridx_bad = LCMP_W'(in_i.read_index) >= (LCMP_W'(1) << n_eff);
    unique case (mode_e'(in_i.mode))
      MODE_GATE: err_in = tq_bad;
      MODE_CNOT: err_in = tq_bad || cq_bad;
      MODE_READ: err_in = ridx_bad;
      default:   err_in = 1'b0;
    endcase
    noop_in = (mode_e'(in_i.mode) == MODE_CNOT) && !err_in &&
              (in_i.target_qubit == in_i.control_qubit);
  end

  // Pair addressing: a zero is inserted into the pair count at the target bit.
  always_comb begin
    tbit      = ADDR_W'(1) << tq_q;
    cbit      = ADDR_W'(1) << cq_q;
    low_mask  = tbit - ADDR_W'(1);
    addr_i    = ((pair_q & ~low_mask) << 1) | (pair_q & low_mask);
    addr_j    = addr_i | tbit;
    pair_last = (ADDR_W'(1) << (n_eff - NQ_W'(1))) - ADDR_W'(1);
    last_pair = (pair_q == pair_last);
    skip_pair = (mode_q == MODE_CNOT) && ((addr_i & cbit) == '0);
    clear_end = (pair_q == ADDR_W'(DEPTH - 1));
    mac_done  = (step_q == MAC_CNT_W'(MAC_STEPS));
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clear_end) begin
          state_d = item_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (mode_e'(in_i.mode) == MODE_GROUND) begin
            state_d = ST_CLEAR;
          end else if (err_in || noop_in) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_RD_A;
          end
        end
      end
      ST_RD_A: begin
        if (!skip_pair) begin
          state_d = ST_RD_B;
        end else if (last_pair) begin
          state_d = ST_RESP;
        end
      end
      ST_RD_B: state_d = (mode_q == MODE_READ) ? ST_RESP : ST_LD_B;
      ST_LD_B: state_d = (mode_q == MODE_GATE) ? ST_MAC : ST_WR_A;
      ST_MAC: begin
        if (mac_done) begin
          state_d = ST_WR_A;
        end
      end
      ST_WR_A: state_d = ST_WR_B;
      ST_WR_B: state_d = last_pair ? ST_RESP : ST_RD_A;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and counter control
  always_comb begin
    ram_we         = 1'b0;
    ram_waddr      = addr_i;
    ram_wdata      = b_q;
    ram_raddr      = addr_i;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.step  = step_q[MAC_STEP_W-1:0];
    pair_d         = pair_q;
    step_d         = step_q;
    item_d         = item_q;
    out_load       = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = pair_q;
        ram_wdata = (pair_q == '0) ? '{re: AMP_ONE, im: '0} : '0;
        pair_d    = pair_q + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          item_d = 1'b1;
          pair_d = '0;
        end
      end
      ST_RD_A: begin
        ram_raddr = (mode_q == MODE_READ) ? ADDR_W'(ridx_q) : addr_i;
        if (skip_pair) begin
          pair_d = pair_q + ADDR_W'(1);
        end
      end
      ST_RD_B: ram_raddr = addr_j;
      ST_LD_B: step_d = '0;
      ST_MAC: begin
        mac_ctrl.issue = !mac_done;
        if (!mac_done) begin
          step_d = step_q + MAC_CNT_W'(1);
        end
      end
      ST_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = addr_i;
        ram_wdata = (mode_q == MODE_GATE) ? new_a : b_q;
      end
      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = addr_j;
        ram_wdata = (mode_q == MODE_GATE) ? new_b : a_q;
        pair_d    = pair_q + ADDR_W'(1);
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          item_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      item_q      <= 1'b0;
      pair_q      <= '0;
      step_q      <= '0;
      qcount_q    <= QCNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_q      <= item_d;
      pair_q      <= pair_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        qcount_q <= pwdata[QCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_e'(in_i.mode);
      tq_q   <= in_i.target_qubit;
      cq_q   <= in_i.control_qubit;
      ridx_q <= in_i.read_index;
      u_q[0] <= '{re: in_i.u0_re, im: in_i.u0_im};
      u_q[1] <= '{re: in_i.u1_re, im: in_i.u1_im};
      u_q[2] <= '{re: in_i.u2_re, im: in_i.u2_im};
      u_q[3] <= '{re: in_i.u3_re, im: in_i.u3_im};
      err_q  <= err_in;
    end
    if (state_q == ST_RD_B) begin
      a_q <= ram_rdata;
    end
    if (state_q == ST_LD_B) begin
      b_q <= ram_rdata;
    end
    if (out_load) begin
      if ((mode_q == MODE_READ) && !err_q) begin
        out_re_q <= a_q.re;
        out_im_q <= a_q.im;
      end else begin
        out_re_q <= '0;
        out_im_q <= '0;
      end
      out_status_q <= err_q && (mode_q != MODE_GROUND);
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.amp_re = out_re_q;
  assign out_o.amp_im = out_im_q;
  assign out_o.status = out_status_q;

  qsv_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  qsv_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .amp_a_i (a_q),
    .amp_b_i (b_q),
    .mat_i   (u_q),
    .new_a_o (new_a),
    .new_b_o (new_b)
  );

endmodule

FILE: hdl/qsv_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module qsv_ram #(
  parameter int   WIDTH = 36,
  parameter int   DEPTH = 1024,
  localparam int  AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/qsv_mac.sv
`timescale 1ns / 1ps
// Shared complex multiply-accumulate unit: one real product per cycle while issue is set, four sums.
module qsv_mac (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  qsv_pkg::mac_ctrl_t      ctrl_i,
  input  qsv_pkg::cplx_t          amp_a_i,
  input  qsv_pkg::cplx_t          amp_b_i,
  input  qsv_pkg::mcplx_t [3:0]   mat_i,
  output qsv_pkg::cplx_t          new_a_o,
  output qsv_pkg::cplx_t          new_b_o
);
  import qsv_pkg::*;

  // Step bits [3:2] pick the sum (new a re, new a im, new b re, new b im),
  // bits [1:0] pick the amplitude part (a re, a im, b re, b im).
  logic [1:0] sum_sel;
  logic [1:0] term_sel;
  amp_t       amp_op;
  mcplx_t     mat_entry;
  mat_t       mat_op;
  logic       neg;
  prod_t      prod_d;

  prod_t      prod_q;
  logic       prod_vld_q;
  logic       prod_neg_q;
  logic       prod_first_q;
  logic [1:0] prod_sum_q;

  acc_t       acc_q [4];
  acc_t       acc_base;
  acc_t       acc_ext;
  acc_t       acc_d;

  always_comb begin
    sum_sel   = ctrl_i.step[3:2];
    term_sel  = ctrl_i.step[1:0];
    unique case (term_sel)
      2'd0:    amp_op = amp_a_i.re;
      2'd1:    amp_op = amp_a_i.im;
      2'd2:    amp_op = amp_b_i.re;
      default: amp_op = amp_b_i.im;
    endcase
    mat_entry = mat_i[{term_sel[1], sum_sel[1]}];
    mat_op    = (sum_sel[0] ^ term_sel[0]) ? mat_entry.im : mat_entry.re;
    // Only the real sums subtract, and only the imaginary-by-imaginary terms.
    neg       = !sum_sel[0] && term_sel[0];
    prod_d    = amp_op * mat_op;
  end

  always_comb begin
    acc_base = prod_first_q ? '0 : acc_q[prod_sum_q];
    acc_ext  = ACC_W'(prod_q);
    acc_d    = prod_neg_q ? (acc_base - acc_ext) : (acc_base + acc_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q       <= prod_d;
      prod_neg_q   <= neg;
      prod_first_q <= (term_sel == 2'd0);
      prod_sum_q   <= sum_sel;
    end
    if (prod_vld_q) begin
      acc_q[prod_sum_q] <= acc_d;
    end
  end

  assign new_a_o = '{re: round_sat(acc_q[0]), im: round_sat(acc_q[1])};
  assign new_b_o = '{re: round_sat(acc_q[2]), im: round_sat(acc_q[3])};

endmodule

FILE: hdl/qsv_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the gate engine and the bind that attaches them.
module qsv_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [qsv_pkg::AMP_W-1:0] amp_re_i,
  input logic signed [qsv_pkg::AMP_W-1:0] amp_im_i,
  input logic                             status_i
);
  import qsv_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(amp_re_i) && $stable(amp_im_i) &&
                                    $stable(status_i))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> (amp_re_i == '0) && (amp_im_i == '0))
    else $error("flagged result carries a non-zero amplitude");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("engine ready straight after taking a command");

  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result posted while the engine was still busy");

endmodule

bind qubit_state_vector_gate_engine qsv_checker u_qsv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .amp_re_i    (out_o.amp_re),
  .amp_im_i    (out_o.amp_im),
  .status_i    (out_o.status)
);

FILE: tb/sv/qubit_state_vector_gate_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the qubit state-vector gate engine, with its own state-vector predictor.
module qubit_state_vector_gate_engine_test;
  import qsv_pkg::*;

  localparam int ONE         = 65536;
  localparam int HALF        = 32768;
  localparam int HALF_ROOT   = 46341;
  localparam int MAT_MAX     = 131071;
  localparam int MAT_MIN     = -131072;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 50;

  typedef struct packed {
    mode_e              mode;
    logic [QIDX_W-1:0]  target;
    logic [QIDX_W-1:0]  control;
    mcplx_t [3:0]       m;
    logic [RIDX_W-1:0]  index;
  } gate_cmd_t;

  typedef struct packed {
    cplx_t amp;
    logic  status;
  } amp_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  qsv_in_if  cmd_bus ();
  qsv_out_if res_bus ();

  qubit_state_vector_gate_engine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_bus),
    .out_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted contents of the amplitude store and the qubit count register.
  cplx_t             amp_store [DEPTH];
  logic [QCNT_W-1:0] qubit_count_model;

  amp_result_t pending_results [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          command_burst = 1'b0;
  bit          result_burst = 1'b0;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count == CYCLE_LIMIT);
    $display("qubit_state_vector_gate_engine_test: done, errors");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    if (error_count < 100) begin
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    end
    error_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned active_qubits();
    return (qubit_count_model > MAX_QUBITS) ? MAX_QUBITS : int'(qubit_count_model);
  endfunction

  function automatic void clear_store();
    for (int i = 0; i < DEPTH; i++) begin
      amp_store[i] = '0;
    end
    amp_store[0].re = AMP_ONE;
  endfunction

  // Rounds a sum with 32 fraction bits to 16, half up, and clamps it to the amplitude range.
  function automatic amp_t settle_sum(longint acc);
    longint hi;
    longint lo;
    longint q;
    hi = (longint'(1) << (AMP_W - 1)) - 1;
    lo = -hi - 1;
    q  = (acc + longint'(HALF)) >>> FRAC_BITS;
    if (q > hi) begin
      q = hi;
    end else if (q < lo) begin
      q = lo;
    end
    return amp_t'(q);
  endfunction

  // One output amplitude of a gate: a * ua + b * ub, in complex arithmetic.
  function automatic cplx_t mix_pair(cplx_t a, cplx_t b, mcplx_t ua, mcplx_t ub);
    amp_t  ar, ai, br, bi;
    mat_t  xr, xi, yr, yi;
    cplx_t r;
    ar = a.re;
    ai = a.im;
    br = b.re;
    bi = b.im;
    xr = ua.re;
    xi = ua.im;
    yr = ub.re;
    yi = ub.im;
    r.re = settle_sum(longint'(ar) * longint'(xr) - longint'(ai) * longint'(xi)
                    + longint'(br) * longint'(yr) - longint'(bi) * longint'(yi));
    r.im = settle_sum(longint'(ar) * longint'(xi) + longint'(ai) * longint'(xr)
                    + longint'(br) * longint'(yi) + longint'(bi) * longint'(yr));
    return r;
  endfunction

  function automatic amp_result_t apply_command(gate_cmd_t c);
    amp_result_t r;
    int unsigned n, len, tb, cb, i, j;
    cplx_t       a, b;
    r   = '0;
    n   = active_qubits();
    len = 1 << n;
    case (c.mode)
      MODE_GROUND: begin
        clear_store();
      end
      MODE_GATE: begin
        if (c.target >= n) begin
          r.status = 1'b1;
        end else begin
          tb = 1 << c.target;
          for (i = 0; i < len; i++) begin
            if ((i & tb) == 0) begin
              j = i | tb;
              a = amp_store[i];
              b = amp_store[j];
              amp_store[i] = mix_pair(a, b, c.m[0], c.m[2]);
              amp_store[j] = mix_pair(a, b, c.m[1], c.m[3]);
            end
          end
        end
      end
      MODE_CNOT: begin
        if (c.target >= n || c.control >= n) begin
          r.status = 1'b1;
        end else if (c.target != c.control) begin
          tb = 1 << c.target;
          cb = 1 << c.control;
          for (i = 0; i < len; i++) begin
            if ((i & tb) == 0 && (i & cb) != 0) begin
              j = i | tb;
              a = amp_store[i];
              amp_store[i] = amp_store[j];
              amp_store[j] = a;
            end
          end
        end
      end
      default: begin
        if (c.index >= len) begin
          r.status = 1'b1;
        end else begin
          r.amp = amp_store[c.index];
        end
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- commands

  // Fields that the mode does not use carry random content.
  function automatic gate_cmd_t noise_cmd(mode_e md);
    logic [191:0] bits;
    gate_cmd_t    c;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    c = bits[$bits(gate_cmd_t)-1:0];
    c.mode = md;
    return c;
  endfunction

  function automatic gate_cmd_t ground_cmd();
    return noise_cmd(MODE_GROUND);
  endfunction

  function automatic gate_cmd_t read_cmd(int idx);
    gate_cmd_t c;
    c = noise_cmd(MODE_READ);
    c.index = idx;
    return c;
  endfunction

  function automatic gate_cmd_t cnot_cmd(int cq, int tq);
    gate_cmd_t c;
    c = noise_cmd(MODE_CNOT);
    c.control = cq;
    c.target  = tq;
    return c;
  endfunction

  function automatic gate_cmd_t gate_cmd(int tq, int u0r, int u0i, int u1r, int u1i,
                                         int u2r, int u2i, int u3r, int u3i);
    gate_cmd_t c;
    c = noise_cmd(MODE_GATE);
    c.target  = tq;
    c.m[0].re = mat_t'(u0r);
    c.m[0].im = mat_t'(u0i);
    c.m[1].re = mat_t'(u1r);
    c.m[1].im = mat_t'(u1i);
    c.m[2].re = mat_t'(u2r);
    c.m[2].im = mat_t'(u2i);
    c.m[3].re = mat_t'(u3r);
    c.m[3].im = mat_t'(u3i);
    return c;
  endfunction

  function automatic mat_t unit_level();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return mat_t'(ONE);
      2:       return mat_t'(-ONE);
      3:       return mat_t'(HALF_ROOT);
      default: return mat_t'(-HALF_ROOT);
    endcase
  endfunction

  // Full-range entries drive the sums into saturation; the milder ones keep the state readable.
  function automatic mcplx_t pick_entry(int unsigned style);
    mcplx_t e;
    if (style < 15) begin
      e.re = mat_t'($urandom);
      e.im = mat_t'($urandom);
    end else if (style < 55) begin
      e.re = mat_t'(int'($urandom_range(0, 2 * HALF)) - HALF);
      e.im = mat_t'(int'($urandom_range(0, 2 * HALF)) - HALF);
    end else begin
      e.re = unit_level();
      e.im = ($urandom_range(0, 1) != 0) ? mat_t'(0) : unit_level();
    end
    return e;
  endfunction

  function automatic gate_cmd_t random_cmd(bit heavy);
    gate_cmd_t   c;
    int unsigned n, pick, style;
    n    = active_qubits();
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      c = noise_cmd(MODE_GROUND);
    end else if (pick < (heavy ? 10 : 35)) begin
      c = noise_cmd(MODE_GATE);
    end else if (pick < (heavy ? 30 : 55)) begin
      c = noise_cmd(MODE_CNOT);
    end else begin
      c = noise_cmd(MODE_READ);
    end
    if (n > 0 && $urandom_range(0, 9) != 0) begin
      c.target = $urandom_range(0, n - 1);
    end
    if (n > 0 && $urandom_range(0, 9) != 0) begin
      c.control = ($urandom_range(0, 7) == 0) ? c.target : $urandom_range(0, n - 1);
    end
    if ($urandom_range(0, 4) != 0) begin
      c.index = $urandom_range(0, (1 << n) - 1);
    end
    style = $urandom_range(0, 99);
    for (int k = 0; k < 4; k++) begin
      c.m[k] = pick_entry(style);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- channels

  task automatic send_command(gate_cmd_t c);
    int unsigned gap;
    gap = command_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.mode          <= c.mode;
    cmd_bus.target_qubit  <= c.target;
    cmd_bus.control_qubit <= c.control;
    cmd_bus.u0_re         <= c.m[0].re;
    cmd_bus.u0_im         <= c.m[0].im;
    cmd_bus.u1_re         <= c.m[1].re;
    cmd_bus.u1_im         <= c.m[1].im;
    cmd_bus.u2_re         <= c.m[2].re;
    cmd_bus.u2_im         <= c.m[2].im;
    cmd_bus.u3_re         <= c.m[3].re;
    cmd_bus.u3_im         <= c.m[3].im;
    cmd_bus.read_index    <= c.index;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    pending_results.push_back(apply_command(c));
  endtask

  // Valid stays high after a transaction so that back-to-back commands need no gap.
  task automatic drain_results();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin : result_checker
    amp_result_t want;
    int unsigned stall;
    res_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = result_burst ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_bus.valid) @(posedge clk_i);
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command outstanding, status", res_bus.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.amp_re !== want.amp.re) begin
          report_mismatch("amp_re", $signed(res_bus.amp_re), $signed(want.amp.re));
        end
        if (res_bus.amp_im !== want.amp.im) begin
          report_mismatch("amp_im", $signed(res_bus.amp_im), $signed(want.amp.im));
        end
        if (res_bus.status !== want.status) begin
          report_mismatch("status", res_bus.status, want.status);
        end
      end
    end
  end

  task automatic apb_access(input logic write_en, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {REG_QUBIT_COUNT, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Only bits above the count field get random filler; the register keeps the low bits.
  task automatic write_qubit_count(logic [QCNT_W-1:0] count);
    logic [PDATA_W-1:0] word;
    logic [PDATA_W-1:0] readback;
    drain_results();
    word = ($urandom_range(0, 1) != 0) ? PDATA_W'($urandom) : '0;
    word[QCNT_W-1:0] = count;
    apb_access(1'b1, word, readback);
    qubit_count_model = count;
    apb_access(1'b0, '0, readback);
    if (readback !== PDATA_W'(count)) begin
      report_mismatch("qubit_count readback", readback, count);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    logic [PDATA_W-1:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback !== PDATA_W'(QCNT_RESET)) begin
      report_mismatch("qubit_count after reset", readback, QCNT_RESET);
    end
    send_command(read_cmd(0));
    send_command(read_cmd(2));
  endtask

  task automatic test_gate_and_cnot();
    write_qubit_count(2);
    send_command(gate_cmd(0, 0, 0, ONE, 0, ONE, 0, 0, 0));
    send_command(gate_cmd(1, HALF_ROOT, 0, HALF_ROOT, 0, HALF_ROOT, 0, -HALF_ROOT, 0));
    send_command(cnot_cmd(0, 1));
    send_command(read_cmd(3));
    send_command(cnot_cmd(1, 1));
    send_command(cnot_cmd(0, 2));
    send_command(cnot_cmd(15, 0));
    send_command(gate_cmd(15, ONE, 0, 0, 0, 0, 0, ONE, 0));
    send_command(read_cmd(4));
  endtask

  // Three times minus one half lands exactly on a half, which must round upwards.
  task automatic test_rounding_and_saturation();
    write_qubit_count(1);
    send_command(ground_cmd());
    send_command(gate_cmd(0, 3, 0, 0, 0, 0, 0, ONE, 0));
    send_command(gate_cmd(0, -HALF, 0, 0, 0, 0, 0, ONE, 0));
    send_command(read_cmd(0));
    send_command(ground_cmd());
    repeat (2) begin
      send_command(gate_cmd(0, MAT_MAX, MAT_MIN, MAT_MIN, MAT_MAX,
                            MAT_MAX, MAT_MAX, MAT_MIN, MAT_MIN));
    end
    send_command(read_cmd(1));
  endtask

  // A count of zero leaves a single amplitude; counts above the maximum act as the maximum.
  task automatic test_qubit_count_extremes();
    write_qubit_count(0);
    send_command(read_cmd(0));
    send_command(gate_cmd(0, 0, 0, ONE, 0, ONE, 0, 0, 0));
    write_qubit_count(15);
    send_command(gate_cmd(9, 0, 0, ONE, 0, ONE, 0, 0, 0));
    send_command(cnot_cmd(9, 0));
    send_command(read_cmd(513));
    send_command(read_cmd(1023));
  endtask

  task automatic run_random_phase(int count, int items, bit heavy);
    write_qubit_count(count);
    for (int k = 0; k < items; k++) begin
      if (k % 24 == 0) begin
        command_burst = ($urandom_range(0, 3) == 0);
        result_burst  = ($urandom_range(0, 3) == 0);
      end
      send_command(random_cmd(heavy));
    end
    command_burst = 1'b0;
    result_burst  = 1'b0;
  endtask

  // Gates are costly with many qubits, so the large counts see mostly reads and swaps.
  task automatic test_random_traffic();
    run_random_phase(1, 200, 1'b0);
    run_random_phase(2, 200, 1'b0);
    run_random_phase(3, 240, 1'b0);
    run_random_phase(4, 200, 1'b0);
    run_random_phase(5, 150, 1'b0);
    run_random_phase(0, 40, 1'b0);
    run_random_phase(7, 60, 1'b0);
    run_random_phase(10, 40, 1'b1);
    run_random_phase(15, 25, 1'b1);
  endtask

  initial begin
    rst_ni                <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    cmd_bus.valid         <= 1'b0;
    cmd_bus.mode          <= MODE_GROUND;
    cmd_bus.target_qubit  <= '0;
    cmd_bus.control_qubit <= '0;
    cmd_bus.u0_re         <= '0;
    cmd_bus.u0_im         <= '0;
    cmd_bus.u1_re         <= '0;
    cmd_bus.u1_im         <= '0;
    cmd_bus.u2_re         <= '0;
    cmd_bus.u2_im         <= '0;
    cmd_bus.u3_re         <= '0;
    cmd_bus.u3_im         <= '0;
    cmd_bus.read_index    <= '0;
    clear_store();
    qubit_count_model = QCNT_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The store is swept clean after reset before the first command is taken.
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);

    test_reset_state();
    test_gate_and_cnot();
    test_rounding_and_saturation();
    test_qubit_count_extremes();
    test_random_traffic();

    drain_results();
    repeat (SETTLE) @(posedge clk_i);
    if (error_count == 0) begin
      $display("qubit_state_vector_gate_engine_test: done, clean");
    end else begin
      $display("qubit_state_vector_gate_engine_test: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/qsv_pkg.sv
hdl/qsv_in_if.sv
hdl/qsv_out_if.sv
hdl/qsv_ram.sv
hdl/qsv_mac.sv
hdl/qubit_state_vector_gate_engine.sv
hdl/qsv_checker.sv
tb/sv/qubit_state_vector_gate_engine_test.sv
